FILE: rtl/salc_pkg.sv
// Shared constants and types for the set-associative tag cache with next-line prefetch.
package salc_pkg;

  localparam int unsigned DefWays      = 4;
  localparam int unsigned DefSets      = 128;
  localparam int unsigned DefLineBytes = 32;
  localparam int unsigned DefAddrBits  = 32;

  localparam logic RegAllocOnStore = 1'b0;
  localparam logic RegPrefetchMode = 1'b1;

  typedef enum logic [1:0] {
    PF_OFF    = 2'd0,
    PF_ALWAYS = 2'd1,
    PF_MISS   = 2'd2,
    PF_UNUSED = 2'd3
  } pf_mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_DEMAND,
    ST_UPD_DEMAND,
    ST_RD_PREFETCH,
    ST_UPD_PREFETCH
  } state_e;

endpackage

FILE: rtl/salc_if.sv
// Valid/ready channels for access words and result words.
interface salc_in_if;
  logic        valid;
  logic        ready;
  logic        is_store;
  logic [31:0] address;
  modport source (output valid, is_store, address, input ready);
  modport sink   (input valid, is_store, address, output ready);
endinterface

interface salc_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [3:0]  hit_way;
  logic        prefetch_filled;
  logic [31:0] hit_total;
  modport source (output valid, hit, hit_way, prefetch_filled, hit_total, input ready);
  modport sink   (input valid, hit, hit_way, prefetch_filled, hit_total, output ready);
endinterface

FILE: rtl/set_assoc_lru_cache_prefetch_core.sv
// Tag-only set-associative cache with true LRU and a next-line prefetcher.
//
//   channel   dir   handshake      payload
//   in_port   in    valid/ready    is_store, address
//   out_port  out   valid/ready    hit, hit_way, prefetch_filled, hit_total
//   cfg       in    cfg_we_i       cfg_idx_i, cfg_data_i
//
// An access reads and updates the demand set, then, if a prefetch is needed, the
// next line's set; a store miss without allocation writes no row back.
// After reset a clearing pass writes one set a cycle, every set in turn, before the
// first word is accepted. A result word waits in an output register; a new
// word is accepted meanwhile, and its last update waits until that register frees.
module set_assoc_lru_cache_prefetch_core #(
  parameter int unsigned WAYS       = salc_pkg::DefWays,
  parameter int unsigned SETS       = salc_pkg::DefSets,
  parameter int unsigned LINE_BYTES = salc_pkg::DefLineBytes,
  parameter int unsigned ADDR_BITS  = salc_pkg::DefAddrBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [1:0]  cfg_data_i,
  salc_in_if.sink     in_port,
  salc_out_if.source  out_port
);
  import salc_pkg::*;

  localparam int unsigned OFF_W  = $clog2(LINE_BYTES);
  localparam int unsigned SETL_W = $clog2(SETS);
  localparam int unsigned SIDX_W = (SETS > 1) ? SETL_W : 1;
  localparam int unsigned BLK_W  = ADDR_BITS - OFF_W;
  localparam int unsigned TAG_W  = BLK_W - SETL_W;
  localparam int unsigned RW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W  = WAYS * (1 + TAG_W + RW);

  state_e state_q, state_d;

  logic                  alloc_q;
  logic [1:0]            mode_q;
  logic                  store_q;
  logic [BLK_W-1:0]      dblk_q;
  logic                  dhit_q;
  logic [RW-1:0]         dway_q;
  logic [31:0]           hits_q;
  logic [SIDX_W-1:0]     clr_q;

  logic                  ov_q;
  logic                  o_hit_q;
  logic [3:0]            o_way_q;
  logic                  o_pf_q;
  logic [31:0]           o_tot_q;

  logic [ROW_W-1:0]      mem [SETS];
  logic [ROW_W-1:0]      rdata_q;
  logic                  mem_re, mem_we;
  logic [SIDX_W-1:0]     mem_ra, mem_wa;
  logic [ROW_W-1:0]      mem_wd;

  logic [ADDR_BITS-1:0]  addr_ext;
  logic [BLK_W-1:0]      pblk;
  logic [SIDX_W-1:0]     dset, pset;
  logic [TAG_W-1:0]      dtag, ptag;

  logic [WAYS-1:0]            r_v, n_v;
  logic [WAYS-1:0][TAG_W-1:0] r_t, n_t;
  logic [WAYS-1:0][RW-1:0]    r_r, n_r;
  logic [TAG_W-1:0]      lk_tag;
  logic                  lk_alloc, lk_hit, lk_upd, lk_any_inv;
  logic [RW-1:0]         lk_hway, lk_inv, lk_max, lk_sel;
  logic [RW:0]           lk_old;

  logic                  out_free, need_pf, last_step, go;

  assign addr_ext = ADDR_BITS'(in_port.address);
  assign pblk     = dblk_q + BLK_W'(1);
  assign dset     = SIDX_W'(dblk_q % SETS);
  assign pset     = SIDX_W'(pblk % SETS);
  assign dtag     = TAG_W'(dblk_q / SETS);
  assign ptag     = TAG_W'(pblk / SETS);

  assign {r_v, r_t, r_r} = rdata_q;
  assign lk_tag   = (state_q == ST_UPD_PREFETCH) ? ptag : dtag;
  assign lk_alloc = (state_q == ST_UPD_PREFETCH) || !store_q || alloc_q;

  always_comb begin
    lk_hit     = 1'b0;
    lk_hway    = '0;
    lk_any_inv = 1'b0;
    lk_inv     = '0;
    lk_max     = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (r_v[w] && r_t[w] == lk_tag) begin
        lk_hit  = 1'b1;
        lk_hway = RW'(w);
      end
      if (!r_v[w]) begin
        lk_any_inv = 1'b1;
        lk_inv     = RW'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (r_r[w] > r_r[lk_max]) lk_max = RW'(w);
    end
    lk_sel = lk_hit ? lk_hway : (lk_any_inv ? lk_inv : lk_max);
    lk_upd = lk_hit || lk_alloc;
    lk_old = r_v[lk_sel] ? {1'b0, r_r[lk_sel]} : (RW + 1)'(WAYS);
    for (int w = 0; w < WAYS; w++) begin
      n_v[w] = r_v[w];
      n_t[w] = r_t[w];
      n_r[w] = r_r[w];
      if (RW'(w) == lk_sel) begin
        n_v[w] = 1'b1;
        n_t[w] = lk_tag;
        n_r[w] = '0;
      end else if (r_v[w] && {1'b0, r_r[w]} < lk_old && r_r[w] < RW'(WAYS - 1)) begin
        n_r[w] = r_r[w] + RW'(1);
      end
    end
  end

  assign out_free  = !ov_q || out_port.ready;
  assign need_pf   = (mode_q == PF_ALWAYS) || (mode_q == PF_MISS && !lk_hit);
  assign last_step = (state_q == ST_UPD_PREFETCH) || (state_q == ST_UPD_DEMAND && !need_pf);
  assign go        = !last_step || out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:        if (clr_q == SIDX_W'(SETS - 1)) state_d = ST_IDLE;
      ST_IDLE:         if (in_port.valid) state_d = ST_RD_DEMAND;
      ST_RD_DEMAND:    state_d = ST_UPD_DEMAND;
      ST_UPD_DEMAND:   if (go) state_d = need_pf ? ST_RD_PREFETCH : ST_IDLE;
      ST_RD_PREFETCH:  state_d = ST_UPD_PREFETCH;
      ST_UPD_PREFETCH: if (go) state_d = ST_IDLE;
      default:         state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_re = 1'b0;
    mem_ra = dset;
    mem_we = 1'b0;
    mem_wa = dset;
    mem_wd = {n_v, n_t, n_r};
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
      end
      ST_RD_DEMAND:    mem_re = 1'b1;
      ST_UPD_DEMAND:   mem_we = go && lk_upd;
      ST_RD_PREFETCH: begin
        mem_re = 1'b1;
        mem_ra = pset;
      end
      ST_UPD_PREFETCH: begin
        mem_we = go;
        mem_wa = pset;
      end
      default: ;
    endcase
  end

  assign in_port.ready            = (state_q == ST_IDLE);
  assign out_port.valid           = ov_q;
  assign out_port.hit             = o_hit_q;
  assign out_port.hit_way         = o_way_q;
  assign out_port.prefetch_filled = o_pf_q;
  assign out_port.hit_total       = o_tot_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (in_port.valid && in_port.ready) begin
      store_q <= in_port.is_store;
      dblk_q  <= addr_ext[ADDR_BITS-1:OFF_W];
    end
    if (state_q == ST_UPD_DEMAND && go) begin
      dhit_q <= lk_hit;
      dway_q <= lk_upd ? lk_sel : '0;
    end
    if (last_step && go) begin
      o_hit_q <= (state_q == ST_UPD_DEMAND) ? lk_hit : dhit_q;
      o_way_q <= 4'((state_q == ST_UPD_DEMAND) ? (lk_upd ? lk_sel : RW'(0)) : dway_q);
      o_pf_q  <= (state_q == ST_UPD_PREFETCH) && !lk_hit;
      o_tot_q <= (state_q == ST_UPD_DEMAND && lk_hit && hits_q != '1) ?
                 hits_q + 32'd1 : hits_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      alloc_q <= 1'b1;
      mode_q  <= PF_OFF;
      hits_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + SIDX_W'(1);
      if (cfg_we_i && cfg_idx_i == RegAllocOnStore) alloc_q <= cfg_data_i[0];
      if (cfg_we_i && cfg_idx_i == RegPrefetchMode) mode_q <= cfg_data_i;
      if (state_q == ST_UPD_DEMAND && go && lk_hit && hits_q != '1) hits_q <= hits_q + 32'd1;
      if (last_step && go) ov_q <= 1'b1;
      else if (out_port.ready) ov_q <= 1'b0;
    end
  end

endmodule

FILE: bench/tb_top.sv
// Testbench for the set-associative LRU tag cache with next-line prefetch.
`timescale 1ns / 1ps
module tb_top;
  import salc_pkg::*;

  localparam int unsigned NWays = DefWays;
  localparam int unsigned NSets = DefSets;
  localparam int unsigned LineB = DefLineBytes;
  localparam int unsigned LineShift = $clog2(LineB);
  localparam int unsigned SetShift = $clog2(NSets);
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic        hit;
    logic [3:0]  hit_way;
    logic        prefetch_filled;
    logic [31:0] hit_total;
  } access_result_t;

  class cache_scoreboard;
    logic        line_valid [NSets][NWays];
    logic [31:0] line_tag   [NSets][NWays];
    int unsigned line_age   [NSets][NWays];
    logic [31:0] hit_count;
    logic        alloc_store;
    pf_mode_e    pf_mode;
    access_result_t pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned hits_checked;
    int unsigned prefetch_fills;

    function new();
      for (int s = 0; s < NSets; s++) begin
        for (int w = 0; w < NWays; w++) begin
          line_valid[s][w] = 1'b0;
          line_tag[s][w] = '0;
          line_age[s][w] = 0;
        end
      end
      hit_count = '0;
      alloc_store = 1'b1;
      pf_mode = PF_OFF;
      errors = 0;
      checked = 0;
      hits_checked = 0;
      prefetch_fills = 0;
    endfunction

    function int lookup(int unsigned s, logic [31:0] tg);
      for (int w = 0; w < NWays; w++) begin
        if (line_valid[s][w] && line_tag[s][w] == tg) return w;
      end
      return -1;
    endfunction

    function void promote(int unsigned s, int unsigned way, int unsigned old_age);
      for (int w = 0; w < NWays; w++) begin
        if (w != way && line_valid[s][w] && line_age[s][w] < old_age &&
            line_age[s][w] < NWays - 1)
          line_age[s][w]++;
      end
      line_age[s][way] = 0;
    endfunction

    function int unsigned allocate(int unsigned s, logic [31:0] tg);
      int unsigned victim;
      int unsigned old_age;
      victim = NWays;
      for (int w = NWays - 1; w >= 0; w--) begin
        if (!line_valid[s][w]) victim = w;
      end
      if (victim == NWays) begin
        victim = 0;
        for (int w = 1; w < NWays; w++) begin
          if (line_age[s][w] > line_age[s][victim]) victim = w;
        end
      end
      old_age = line_valid[s][victim] ? line_age[s][victim] : NWays;
      promote(s, victim, old_age);
      line_valid[s][victim] = 1'b1;
      line_tag[s][victim] = tg;
      return victim;
    endfunction

    function void note_access(logic st, logic [31:0] addr);
      access_result_t r;
      logic [31:0] blk;
      logic [31:0] nblk;
      int unsigned s;
      int way;
      r = '0;
      blk = addr >> LineShift;
      s = blk % NSets;
      way = lookup(s, blk >> SetShift);
      if (way >= 0) begin
        r.hit = 1'b1;
        r.hit_way = 4'(way);
        promote(s, way, line_age[s][way]);
        if (hit_count != 32'hFFFF_FFFF) hit_count++;
      end else if (!st || alloc_store) begin
        r.hit_way = 4'(allocate(s, blk >> SetShift));
      end
      if (pf_mode == PF_ALWAYS || (pf_mode == PF_MISS && !r.hit)) begin
        nblk = (blk + 1) & ((32'd1 << (32 - LineShift)) - 1);
        s = nblk % NSets;
        way = lookup(s, nblk >> SetShift);
        if (way >= 0) begin
          promote(s, way, line_age[s][way]);
        end else begin
          void'(allocate(s, nblk >> SetShift));
          r.prefetch_filled = 1'b1;
        end
      end
      r.hit_total = hit_count;
      pending = {pending, r};
    endfunction

    function void check_result(access_result_t got);
      access_result_t exp_r;
      if (pending.size() == 0) begin
        report("result word with nothing pending");
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.hit) hits_checked++;
      if (got.prefetch_filled) prefetch_fills++;
      if (got.hit !== exp_r.hit) report($sformatf("hit %b want %b", got.hit, exp_r.hit));
      if (got.hit_way !== exp_r.hit_way)
        report($sformatf("hit_way %0d want %0d", got.hit_way, exp_r.hit_way));
      if (got.prefetch_filled !== exp_r.prefetch_filled)
        report($sformatf("prefetch_filled %b want %b", got.prefetch_filled,
                         exp_r.prefetch_filled));
      if (got.hit_total !== exp_r.hit_total)
        report($sformatf("hit_total %0d want %0d", got.hit_total, exp_r.hit_total));
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH at word %0d: %s", checked, msg);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [1:0] cfg_data_i;
  int unsigned cycles;
  bit long_stall;
  bit stall_on;
  int unsigned sent;

  salc_in_if  in_ch ();
  salc_out_if out_ch ();
  cache_scoreboard sb;

  set_assoc_lru_cache_prefetch_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_port(in_ch.sink),
    .out_port(out_ch.source)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial sb = new();

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) sb.note_access(in_ch.is_store, in_ch.address);
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.hit, out_ch.hit_way, out_ch.prefetch_filled, out_ch.hit_total});
  end

  // The receiver stalls in short runs, or for a long stretch when asked.
  always @(posedge clk_i) begin
    if (long_stall) begin
      out_ch.ready <= 1'b0;
    end else if (stall_on) begin
      if ($urandom_range(0, 5) == 0) stall_on <= 1'b0;
      out_ch.ready <= $urandom_range(0, 3) == 0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 40) == 0) stall_on <= 1'b1;
    end
  end

  task automatic write_reg(logic idx, logic [1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegAllocOnStore) sb.alloc_store = val[0];
    else sb.pf_mode = pf_mode_e'(val);
  endtask

  task automatic send_access(logic st, logic [31:0] addr);
    in_ch.valid <= 1'b1;
    in_ch.is_store <= st;
    in_ch.address <= addr;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  task automatic pause_sender();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Addresses mostly fall in a few sets with a few tags, so sets fill and evict.
  function automatic logic [31:0] pick_address();
    logic [31:0] a;
    case ($urandom_range(0, 9))
      0: a = $urandom();
      1: a = 32'hFFFF_FFE0 | $urandom_range(0, 31);
      2, 3: a = (($urandom_range(0, 7) << (LineShift + SetShift)) |
                 ($urandom_range(0, 3) << LineShift)) | $urandom_range(0, 31);
      default: a = (($urandom_range(0, 5) << (LineShift + SetShift)) |
                    ($urandom_range(120, 127) << LineShift)) ^ ($urandom() & 32'h1F);
    endcase
    return a;
  endfunction

  task automatic random_phase(int unsigned n);
    int unsigned burst;
    burst = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) pause_sender();
      end
      burst--;
      send_access($urandom_range(0, 1), pick_address());
    end
    drain();
  endtask

  initial begin
    cycles = 0;
    sent = 0;
    long_stall = 1'b0;
    stall_on = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegAllocOnStore;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.is_store = 1'b0;
    in_ch.address = '0;
    out_ch.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, same-set fills past the way count, wraparound.
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b0, 32'h0000_001F);
    send_access(1'b1, 32'hFFFF_FFFF);
    for (int t = 0; t < 6; t++) send_access(1'b0, t << (LineShift + SetShift));
    send_access(1'b0, 32'h0000_0000);
    drain();
    write_reg(RegAllocOnStore, 2'd0);
    write_reg(RegPrefetchMode, PF_ALWAYS);
    send_access(1'b1, 32'h1234_5600);
    send_access(1'b0, 32'hFFFF_FFE0);
    send_access(1'b0, 32'h0000_0FE0);
    send_access(1'b1, 32'hAAAA_5555);
    drain();
    write_reg(RegPrefetchMode, PF_MISS);
    send_access(1'b1, 32'h5555_AAAA);
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b0, 32'h0000_0020);
    drain();
    write_reg(RegPrefetchMode, PF_UNUSED);
    send_access(1'b0, 32'h7777_0000);
    send_access(1'b0, 32'h8888_0040);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        long_stall = 1'b1;
        repeat (300) @(posedge clk_i);
        long_stall = 1'b0;
      end
      random_phase(40);
    join

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(RegAllocOnStore, 2'($urandom_range(0, 1)));
      write_reg(RegPrefetchMode, 2'($urandom_range(0, 3)));
      random_phase(95);
    end

    $display("Sent %0d accesses, checked %0d words: %0d hits, %0d prefetch fills.",
             sent, sb.checked, sb.hits_checked, sb.prefetch_fills);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
